/* src/zns_pkg.sv */
package zns_pkg;

  // Fixed field widths
  localparam int POS_W   = 13;
  localparam int LABEL_W = 8;
  localparam int RAD_W   = 11;
  localparam int DIFF_W  = 14;  // coordinate difference, signed
  localparam int SQ_W    = 26;  // one squared difference
  localparam int D2_W    = 27;  // sum of two squares
  localparam int RSQ_W   = 23;  // squared radius, (2047+1)^2 fits

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Item operations
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TILE  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_INNER  = 3'd0;
  localparam logic [2:0] REG_OUTER  = 3'd1;
  localparam logic [2:0] REG_RING   = 3'd2;
  localparam logic [2:0] REG_ERROR  = 3'd3;
  localparam logic [2:0] REG_FORCED = 3'd4;

  localparam logic [RAD_W-1:0]   INNER_RST  = 11'd100;
  localparam logic [RAD_W-1:0]   OUTER_RST  = 11'd200;
  localparam logic [LABEL_W-1:0] RING_RST   = 8'd0;
  localparam logic [LABEL_W-1:0] ERROR_RST  = 8'd255;
  localparam logic [LABEL_W-1:0] FORCED_RST = 8'd70;

  typedef struct packed {
    logic [RAD_W-1:0]   inner_radius;
    logic [RAD_W-1:0]   outer_radius;
    logic [LABEL_W-1:0] ring_label;
    logic [LABEL_W-1:0] error_label;
    logic [LABEL_W-1:0] forced_label;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [LABEL_W-1:0]      label;
    logic [D2_W-1:0]         center_d2;
  } seed_t;

  typedef struct packed {
    logic capture;      // latch the accepted item
    logic diff_center;  // differences to the world center, radius squares
    logic diff_seed;    // differences to the seed just read
    logic square;       // square the differences
    logic mem_we;       // store the loaded seed
    logic zone_latch;   // classify the tile zone, preset the result
    logic scan_cmp;     // compare one seed against the best so far
    logic out_load;     // move the result to the output register
  } cmd_t;

endpackage

/* src/zns_regs.sv */
module zns_regs
  import zns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inner_radius <= INNER_RST;
      cfg.outer_radius <= OUTER_RST;
      cfg.ring_label   <= RING_RST;
      cfg.error_label  <= ERROR_RST;
      cfg.forced_label <= FORCED_RST;
    end else if (wr) begin
      case (idx)
        REG_INNER:  cfg.inner_radius <= pwdata[RAD_W-1:0];
        REG_OUTER:  cfg.outer_radius <= pwdata[RAD_W-1:0];
        REG_RING:   cfg.ring_label   <= pwdata[LABEL_W-1:0];
        REG_ERROR:  cfg.error_label  <= pwdata[LABEL_W-1:0];
        REG_FORCED: cfg.forced_label <= pwdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INNER:  prdata = PDATA_W'(cfg.inner_radius);
      REG_OUTER:  prdata = PDATA_W'(cfg.outer_radius);
      REG_RING:   prdata = PDATA_W'(cfg.ring_label);
      REG_ERROR:  prdata = PDATA_W'(cfg.error_label);
      REG_FORCED: prdata = PDATA_W'(cfg.forced_label);
      default:    prdata = '0;
    endcase
  end

endmodule

/* src/zns_datapath.sv */
module zns_datapath
  import zns_pkg::*;
#(
  parameter int WORLD_SIZE = 1024,
  parameter int MAX_SEEDS  = 64,
  parameter int AW         = 6
) (
  input  logic                       clk,
  input  logic signed [POS_W-1:0]    pos_x,
  input  logic signed [POS_W-1:0]    pos_y,
  input  logic [LABEL_W-1:0]         seed_label,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  input  logic [AW-1:0]              addr,
  output logic                       ring,
  output logic [LABEL_W-1:0]         tile_label
);

  localparam logic signed [DIFF_W-1:0] CENTER = DIFF_W'(WORLD_SIZE / 2);

  seed_t mem [MAX_SEEDS];
  seed_t rdata;

  logic signed [POS_W-1:0]  it_x;
  logic signed [POS_W-1:0]  it_y;
  logic [LABEL_W-1:0]       it_label;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [SQ_W-1:0]          sqx;
  logic [SQ_W-1:0]          sqy;
  logic [D2_W-1:0]          d2;

  logic [RSQ_W-1:0]         in_sq;
  logic [RSQ_W-1:0]         in1_sq;
  logic [RSQ_W-1:0]         out1_sq;
  logic                     t_in;
  logic                     t_out;
  logic                     t_le;

  logic                     found;
  logic [D2_W-1:0]          best;
  logic [LABEL_W-1:0]       result;

  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;
  logic [2*RAD_W-1:0]         prod_in;
  logic [2*RAD_W+1:0]         prod_in1;
  logic [2*RAD_W+1:0]         prod_out1;
  logic [RAD_W:0]             in_p1;
  logic [RAD_W:0]             out_p1;
  logic                       s_in;
  logic                       s_out;
  logic                       elig;

  assign d2        = D2_W'(sqx) + D2_W'(sqy);
  assign prod_x    = dx * dx;
  assign prod_y    = dy * dy;
  assign in_p1     = {1'b0, cfg.inner_radius} + (RAD_W+1)'(1);
  assign out_p1    = {1'b0, cfg.outer_radius} + (RAD_W+1)'(1);
  assign prod_in   = cfg.inner_radius * cfg.inner_radius;
  assign prod_in1  = in_p1 * in_p1;
  assign prod_out1 = out_p1 * out_p1;

  // Ring band test on the tile distance, valid while zone_latch is issued
  assign ring = (d2 >= D2_W'(in_sq)) && (d2 < D2_W'(out1_sq));

  assign s_in  = rdata.center_d2 < D2_W'(in_sq);
  assign s_out = rdata.center_d2 >= D2_W'(out1_sq);
  assign elig  = (t_in && s_in) || (t_out && s_out) ||
                 (t_le && (rdata.label == cfg.forced_label));

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= '{x: it_x, y: it_y, label: it_label, center_d2: d2};
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_x     <= pos_x;
      it_y     <= pos_y;
      it_label <= seed_label;
    end
    if (cmd.diff_center) begin
      dx      <= {it_x[POS_W-1], it_x} - CENTER;
      dy      <= {it_y[POS_W-1], it_y} - CENTER;
      in_sq   <= RSQ_W'(prod_in);
      in1_sq  <= prod_in1[RSQ_W-1:0];
      out1_sq <= prod_out1[RSQ_W-1:0];
    end else if (cmd.diff_seed) begin
      dx <= {it_x[POS_W-1], it_x} - {rdata.x[POS_W-1], rdata.x};
      dy <= {it_y[POS_W-1], it_y} - {rdata.y[POS_W-1], rdata.y};
    end
    if (cmd.square) begin
      sqx <= prod_x[SQ_W-1:0];
      sqy <= prod_y[SQ_W-1:0];
    end
    if (cmd.zone_latch) begin
      t_in   <= d2 < D2_W'(in_sq);
      t_out  <= d2 >= D2_W'(out1_sq);
      t_le   <= d2 < D2_W'(in1_sq);
      found  <= 1'b0;
      result <= ring ? cfg.ring_label : cfg.error_label;
    end else if (cmd.scan_cmp && elig && (!found || d2 < best)) begin
      found  <= 1'b1;
      best   <= d2;
      result <= rdata.label;
    end
    if (cmd.out_load) begin
      tile_label <= result;
    end
  end

endmodule

/* src/zns_ctrl.sv */
module zns_ctrl
  import zns_pkg::*;
#(
  parameter int MAX_SEEDS = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    operation,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          ring,
  output cmd_t          cmd,
  output logic [AW-1:0] addr
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_DIFF,
    S_LOAD_SQ,
    S_LOAD_WR,
    S_TILE_DIFF,
    S_TILE_SQ,
    S_TILE_ZONE,
    S_SEED_RD,
    S_SEED_DIFF,
    S_SEED_SQ,
    S_SEED_CMP,
    S_FINISH
  } state_t;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEEDS);

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic          accept;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign addr     = (state == S_LOAD_WR) ? count[AW-1:0] : idx;

  always_comb begin
    cmd             = '0;
    cmd.capture     = accept;
    cmd.diff_center = (state == S_LOAD_DIFF) || (state == S_TILE_DIFF);
    cmd.diff_seed   = (state == S_SEED_DIFF);
    cmd.square      = (state == S_LOAD_SQ) || (state == S_TILE_SQ) ||
                      (state == S_SEED_SQ);
    cmd.mem_we      = (state == S_LOAD_WR);
    cmd.zone_latch  = (state == S_TILE_ZONE);
    cmd.scan_cmp    = (state == S_SEED_CMP);
    cmd.out_load    = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_CLEAR: count <= '0;
              OP_LOAD: begin
                // drop loads once the table is full
                if (count < MAX_CNT) begin
                  state <= S_LOAD_DIFF;
                end
              end
              OP_TILE: state <= S_TILE_DIFF;
              default: ;
            endcase
          end
        end
        S_LOAD_DIFF: state <= S_LOAD_SQ;
        S_LOAD_SQ:   state <= S_LOAD_WR;
        S_LOAD_WR: begin
          count <= count + CW'(1);
          state <= S_IDLE;
        end
        S_TILE_DIFF: state <= S_TILE_SQ;
        S_TILE_SQ:   state <= S_TILE_ZONE;
        S_TILE_ZONE: begin
          idx <= '0;
          if (ring || (count == '0)) begin
            state <= S_FINISH;
          end else begin
            state <= S_SEED_RD;
          end
        end
        S_SEED_RD:   state <= S_SEED_DIFF;
        S_SEED_DIFF: state <= S_SEED_SQ;
        S_SEED_SQ:   state <= S_SEED_CMP;
        S_SEED_CMP: begin
          if ((CW'(idx) + CW'(1)) == count) begin
            state <= S_FINISH;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SEED_RD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("seed count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED_RD || state == S_SEED_DIFF || state == S_SEED_SQ ||
     state == S_SEED_CMP) |-> (CW'(idx) < count))
    else $error("scan index past loaded seeds");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> (count < MAX_CNT))
    else $error("seed write with full table");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD_WR) |=> (count == $past(count) + CW'(1)))
    else $error("seed count did not advance after write");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && state == S_IDLE))
    else $error("result load did not raise out_valid");

endmodule

/* src/zoned_nearest_seed_labeler_unit.sv */
// Zoned nearest-seed labeler.
// Input channel (in_valid / in_stall) carries one item per beat: operation
// selects clear table, load seed or classify tile; pos_x / pos_y give the
// absolute position and seed_label the label of a loaded seed.
// Output channel (out_valid / out_stall) carries one tile_label beat for each
// classify item; clear and load items give no beat.
// Registers sit on the APB-style port at byte addresses 0, 4, 8, 12, 16:
// inner_radius, outer_radius, ring_label, error_label, forced_label.
// Load steps through difference, square and write states (dropped when the
// table is full); classify steps through difference, square and zone states,
// then scans the loaded seeds unless the tile is in the ring or the table is
// empty. The seed scan reuses one difference/square/compare unit, stepping
// read, difference, square, compare per seed on the single seed memory port.
// in_stall is high while an item is in work. A finished result waits in the
// output register while the receiver stalls, and the next item is taken
// meanwhile; a classify that finishes before the register frees holds.
// Reset empties the seed table, drops any pending result and loads the
// register defaults; seed memory contents stay undefined until loaded.
module zoned_nearest_seed_labeler_unit
  import zns_pkg::*;
#(
  parameter int WORLD_SIZE = 1024,
  parameter int MAX_SEEDS  = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [LABEL_W-1:0]      seed_label,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LABEL_W-1:0]      tile_label
);

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = $clog2(MAX_SEEDS + 1);

  cfg_t          cfg;
  cmd_t          cmd;
  logic [AW-1:0] addr;
  logic          ring;

  zns_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zns_ctrl #(
    .MAX_SEEDS (MAX_SEEDS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ring      (ring),
    .cmd       (cmd),
    .addr      (addr)
  );

  zns_datapath #(
    .WORLD_SIZE (WORLD_SIZE),
    .MAX_SEEDS  (MAX_SEEDS),
    .AW         (AW)
  ) u_datapath (
    .clk        (clk),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .seed_label (seed_label),
    .cfg        (cfg),
    .cmd        (cmd),
    .addr       (addr),
    .ring       (ring),
    .tile_label (tile_label)
  );

endmodule

/* bench/zoned_nearest_seed_labeler_unit_tb.sv */
module zoned_nearest_seed_labeler_unit_tb
  import zns_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORLD_SIZE = 1024;
  localparam int MAX_SEEDS  = 64;
  localparam int CENTER     = WORLD_SIZE / 2;
  // longest classify (full table) plus margin
  localparam int SETTLE_CYCLES = 4 + 4 * MAX_SEEDS + 40;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 195;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic signed [POS_W-1:0] POS_MIN = 13'h1000;
  localparam logic signed [POS_W-1:0] POS_MAX = 13'h0FFF;

  class label_board;
    logic signed [POS_W-1:0] sx [MAX_SEEDS];
    logic signed [POS_W-1:0] sy [MAX_SEEDS];
    logic [LABEL_W-1:0]      slabel [MAX_SEEDS];
    int                      n_seeds;
    logic [RAD_W-1:0]        inner_r, outer_r;
    logic [LABEL_W-1:0]      ring_lbl, err_lbl, forced_lbl;
    logic [LABEL_W-1:0]      label_q [$];
    int                      errors;

    function new();
      n_seeds    = 0;
      inner_r    = INNER_RST;
      outer_r    = OUTER_RST;
      ring_lbl   = RING_RST;
      err_lbl    = ERROR_RST;
      forced_lbl = FORCED_RST;
      errors     = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
      case (idx)
        REG_INNER:  inner_r    = value[RAD_W-1:0];
        REG_OUTER:  outer_r    = value[RAD_W-1:0];
        REG_RING:   ring_lbl   = value[LABEL_W-1:0];
        REG_ERROR:  err_lbl    = value[LABEL_W-1:0];
        REG_FORCED: forced_lbl = value[LABEL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint dist2(input longint ax, input longint ay, input longint bx,
                           input longint by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function logic [LABEL_W-1:0] nearest_label(input logic signed [POS_W-1:0] x,
                                               input logic signed [POS_W-1:0] y);
      longint ir, orad, in_sq, in1_sq, out1_sq, td, sd, d, best;
      bit t_in, t_out, t_le, s_in, s_out, found;
      logic [LABEL_W-1:0] lbl;
      ir      = inner_r;
      orad    = outer_r;
      in_sq   = ir * ir;
      in1_sq  = (ir + 1) * (ir + 1);
      out1_sq = (orad + 1) * (orad + 1);
      td      = dist2(x, y, CENTER, CENTER);
      if (td >= in_sq && td < out1_sq) return ring_lbl;
      t_in  = td < in_sq;
      t_out = td >= out1_sq;
      t_le  = td < in1_sq;
      found = 0;
      best  = 0;
      lbl   = err_lbl;
      for (int i = 0; i < n_seeds; i++) begin
        sd    = dist2(sx[i], sy[i], CENTER, CENTER);
        s_in  = sd < in_sq;
        s_out = sd >= out1_sq;
        if ((t_in && s_in) || (t_out && s_out) || (t_le && slabel[i] == forced_lbl)) begin
          d = dist2(x, y, sx[i], sy[i]);
          // strict compare: the earliest loaded seed keeps a tie
          if (!found || d < best) begin
            found = 1;
            best  = d;
            lbl   = slabel[i];
          end
        end
      end
      return lbl;
    endfunction

    function void note_item(input logic [1:0] op, input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y,
                            input logic [LABEL_W-1:0] lbl);
      case (op)
        OP_CLEAR: n_seeds = 0;
        OP_LOAD: begin
          if (n_seeds < MAX_SEEDS) begin
            sx[n_seeds]     = x;
            sy[n_seeds]     = y;
            slabel[n_seeds] = lbl;
            n_seeds++;
          end
        end
        OP_TILE: label_q.insert(label_q.size(), nearest_label(x, y));
        default: ;
      endcase
    endfunction

    function void check_result(input logic [LABEL_W-1:0] got);
      logic [LABEL_W-1:0] want;
      if (label_q.size() == 0) begin
        $display("%0t: tile_label expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = label_q.pop_front();
        if (got !== want) begin
          $display("%0t: tile_label expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    psel       = 1'b0;
  logic                    penable    = 1'b0;
  logic                    pwrite     = 1'b0;
  logic [PADDR_W-1:0]      paddr      = '0;
  logic [PDATA_W-1:0]      pwdata     = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [1:0]              operation  = OP_CLEAR;
  logic signed [POS_W-1:0] pos_x      = '0;
  logic signed [POS_W-1:0] pos_y      = '0;
  logic [LABEL_W-1:0]      seed_label = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [LABEL_W-1:0]      tile_label;

  label_board board;
  bit         send_burst = 0;
  bit         rx_quiet   = 0;
  int         stall_left = 0;
  int         cycles     = 0;

  zoned_nearest_seed_labeler_unit #(
    .WORLD_SIZE(WORLD_SIZE),
    .MAX_SEEDS (MAX_SEEDS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .seed_label(seed_label),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tile_label(tile_label)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("zoned_nearest_seed_labeler_unit_tb failed");
      $finish;
    end
  end

  // result side: check each beat, then hold stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_result(tile_label);
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [POS_W-1:0] to_pos(input int v);
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return v[POS_W-1:0];
  endfunction

  // aim at the zones under the current radii, on the radius edges now and then
  function automatic void pick_pos(output logic signed [POS_W-1:0] x,
                                   output logic signed [POS_W-1:0] y);
    int mode, s, r, dx, dy;
    mode = $urandom_range(0, 9);
    dx   = 0;
    dy   = 0;
    if (mode < 2) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
      return;
    end
    if (mode < 8) begin
      s  = (mode < 5) ? int'(board.inner_r) + 8 : int'(board.outer_r) + 40;
      dx = int'($urandom_range(0, 2 * s)) - s;
      dy = int'($urandom_range(0, 2 * s)) - s;
    end else begin
      r = ($urandom_range(0, 1) ? int'(board.inner_r) : int'(board.outer_r))
          + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) dx = r;
      else dy = r;
      if ($urandom_range(0, 1)) begin
        dx = -dx;
        dy = -dy;
      end
    end
    x = to_pos(CENTER + dx);
    y = to_pos(CENTER + dy);
  endfunction

  function automatic void pick_seed(output logic signed [POS_W-1:0] x,
                                    output logic signed [POS_W-1:0] y,
                                    output logic [LABEL_W-1:0] lbl);
    int k, n;
    n = (board.n_seeds < MAX_SEEDS) ? board.n_seeds : MAX_SEEDS;
    if (n != 0 && $urandom_range(0, 9) == 0) begin
      // reuse a stored spot so distances tie
      k = $urandom_range(0, n - 1);
      x = board.sx[k];
      y = board.sy[k];
    end else begin
      pick_pos(x, y);
    end
    k = $urandom_range(0, 9);
    if (k < 3) lbl = board.forced_lbl;
    else if (k < 8) lbl = LABEL_W'($urandom_range(0, 15));
    else lbl = LABEL_W'($urandom);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic send_item(input logic [1:0] op, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y,
                           input logic [LABEL_W-1:0] lbl);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    pos_x      <= x;
    pos_y      <= y;
    seed_label <= lbl;
    do @(posedge clk); while (in_stall);
    board.note_item(op, x, y, lbl);
  endtask

  // hold the input side until every pending tile label is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.label_q.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_phase(input int phase);
    logic [PDATA_W-1:0] in_r, out_r, ring, err, forced;
    case (phase)
      1: begin
        in_r = 0; out_r = 0; ring = 0; err = 0; forced = 0;
      end
      2: begin
        in_r = 2047; out_r = 2047; ring = 255; err = 255; forced = 255;
      end
      3: begin
        // inverted radii: no ring, zones may overlap
        in_r   = 300;
        out_r  = 100;
        ring   = $urandom_range(0, 255);
        err    = $urandom_range(0, 255);
        forced = $urandom_range(0, 15);
      end
      default: begin
        in_r   = $urandom_range(0, 700);
        out_r  = $urandom_range(0, 900);
        ring   = $urandom_range(0, 255);
        err    = $urandom_range(0, 255);
        forced = $urandom_range(0, 15);
      end
    endcase
    write_reg(REG_INNER, in_r);
    write_reg(REG_OUTER, out_r);
    write_reg(REG_RING, ring);
    write_reg(REG_ERROR, err);
    write_reg(REG_FORCED, forced);
  endtask

  task automatic directed_items();
    send_item(OP_TILE, to_pos(CENTER), to_pos(CENTER), 8'd0);            // empty table
    send_item(OP_NONE, POS_MIN, POS_MAX, 8'hFF);
    send_item(OP_LOAD, to_pos(CENTER), to_pos(CENTER), 8'd65);
    send_item(OP_LOAD, to_pos(CENTER + 300), to_pos(CENTER), 8'd66);
    send_item(OP_LOAD, to_pos(CENTER + 150), to_pos(CENTER), FORCED_RST);
    send_item(OP_LOAD, to_pos(CENTER), to_pos(CENTER), 8'd67);  // same spot, loses ties
    send_item(OP_TILE, to_pos(CENTER + 5), to_pos(CENTER), 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 99), to_pos(CENTER), 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 100), to_pos(CENTER), 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 200), to_pos(CENTER), 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 201), to_pos(CENTER), 8'd0);
    send_item(OP_TILE, POS_MIN, POS_MIN, 8'd0);
    send_item(OP_TILE, POS_MAX, POS_MAX, 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 150), to_pos(CENTER + 10), 8'd0);
    send_item(OP_CLEAR, POS_MAX, POS_MIN, 8'hFF);
    send_item(OP_TILE, to_pos(CENTER), to_pos(CENTER), 8'd0);
    send_item(OP_LOAD, to_pos(CENTER - 400), to_pos(CENTER), FORCED_RST);
    // only the forced seed fits
    send_item(OP_TILE, to_pos(CENTER + 3), to_pos(CENTER - 3), 8'd0);
    send_item(OP_TILE, to_pos(CENTER + 500), to_pos(CENTER), 8'd0);
    send_item(OP_LOAD, POS_MIN, POS_MAX, 8'd0);
    send_item(OP_TILE, POS_MAX, POS_MIN, 8'd0);
    send_item(OP_TILE, to_pos(CENTER), to_pos(CENTER + 20), 8'd0);
  endtask

  task automatic run_sequences(input int budget);
    int done, n_load, n_tile, r;
    bit first;
    logic [1:0] op;
    logic signed [POS_W-1:0] x, y;
    logic [LABEL_W-1:0] lbl;
    done  = 0;
    first = 1;
    while (done < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        op  = 2'($urandom_range(0, 3));
        x   = POS_W'($urandom);
        y   = POS_W'($urandom);
        lbl = LABEL_W'($urandom);
        send_item(op, x, y, lbl);
        if (op != OP_NONE) done++;
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          send_item(OP_CLEAR, POS_W'($urandom), POS_W'($urandom), LABEL_W'($urandom));
          done++;
        end
        // the first sequence of a phase overfills the table
        r = $urandom_range(0, 9);
        if (first) n_load = $urandom_range(65, 70);
        else if (r < 6) n_load = $urandom_range(0, 8);
        else if (r < 9) n_load = $urandom_range(9, 40);
        else n_load = $urandom_range(60, 70);
        first = 0;
        for (int k = 0; k < n_load; k++) begin
          pick_seed(x, y, lbl);
          send_item(OP_LOAD, x, y, lbl);
          done++;
        end
        n_tile = $urandom_range(4, 16);
        for (int k = 0; k < n_tile; k++) begin
          pick_pos(x, y);
          send_item(OP_TILE, x, y, LABEL_W'($urandom));
          done++;
          if ($urandom_range(0, 59) == 0) drain();
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    settle();
    for (int p = 1; p <= PHASES; p++) begin
      program_phase(p);
      run_sequences(PHASE_ITEMS);
      settle();
    end
    if (board.errors == 0) begin
      $display("zoned_nearest_seed_labeler_unit_tb passed");
    end else begin
      $display("zoned_nearest_seed_labeler_unit_tb failed");
    end
    $finish;
  end

endmodule
